>>> rtl/core/mld_pkg.sv
// mld_pkg: shared constants and helper functions of the mouse-look direction block.
// Used by every module under rtl/core; depends on nothing.
package mld_pkg;

  // Angle format default (fraction bits of the degree accumulators)
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // Port field widths
  localparam int IN_W        = 16;
  localparam int SENS_W      = 16;
  localparam int YAW_OUT_W   = 26;
  localparam int PITCH_OUT_W = 24;
  localparam int VEC_W       = 16;

  localparam logic [SENS_W-1:0] SENS_RESET = 16'd3277;

  // CORDIC datapath: x/y in Q.30, angle in Q.20 degrees
  localparam int TRIG_FRAC    = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_CNT_W = 5;
  localparam int CORDIC_W     = 32;
  localparam int Z_W          = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Product width used for rounding to Q1.15
  localparam int RND_W = 34;

  // arctan(2^-i) in Q.20 degrees
  function automatic logic signed [Z_W-1:0] atan_q20(input logic [CORDIC_CNT_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 30'sd47185920;
      5'd1:    r = 30'sd27855475;
      5'd2:    r = 30'sd14718068;
      5'd3:    r = 30'sd7471121;
      5'd4:    r = 30'sd3750058;
      5'd5:    r = 30'sd1876857;
      5'd6:    r = 30'sd938658;
      5'd7:    r = 30'sd469357;
      5'd8:    r = 30'sd234682;
      5'd9:    r = 30'sd117342;
      5'd10:   r = 30'sd58671;
      5'd11:   r = 30'sd29335;
      5'd12:   r = 30'sd14668;
      5'd13:   r = 30'sd7334;
      5'd14:   r = 30'sd3667;
      5'd15:   r = 30'sd1833;
      5'd16:   r = 30'sd917;
      5'd17:   r = 30'sd458;
      5'd18:   r = 30'sd229;
      5'd19:   r = 30'sd115;
      5'd20:   r = 30'sd57;
      5'd21:   r = 30'sd29;
      5'd22:   r = 30'sd14;
      5'd23:   r = 30'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate to the symmetric Q1.15 range [-32767, 32767]
  function automatic logic signed [VEC_W-1:0] clamp15(input logic signed [RND_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if (v > 34'sd32767) begin
      r = 16'sd32767;
    end else if (v < -34'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[VEC_W-1:0];
    end
    return r;
  endfunction

  // Q1.15 product, rounded half up, saturated
  function automatic logic signed [VEC_W-1:0] mul15(input logic signed [VEC_W-1:0] a,
                                                    input logic signed [VEC_W-1:0] b);
    logic signed [2*VEC_W-1:0] prod;
    logic signed [RND_W-1:0]   rnd;
    prod = a * b;
    rnd  = RND_W'(prod) + 34'sd16384;
    return clamp15(rnd >>> 15);
  endfunction

endpackage

>>> rtl/core/mld_front.sv
// mld_front: accepts cursor items, forms scaled deltas and updates yaw/pitch.
// Holds the sensitivity register. Depends on mld_pkg.
module mld_front #(
  parameter int ANGLE_FRAC_BITS = mld_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int YAW_W           = ANGLE_FRAC_BITS + 10,
  parameter int PITCH_W         = ANGLE_FRAC_BITS + 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [mld_pkg::IN_W-1:0]  cursor_x_i,
  input  logic signed [mld_pkg::IN_W-1:0]  cursor_y_i,
  input  logic                             cfg_valid_i,
  input  logic [mld_pkg::SENS_W-1:0]       cfg_data_i,
  output logic                             push_o,
  input  logic                             full_i,
  output logic signed [YAW_W-1:0]          yaw_o,
  output logic signed [PITCH_W-1:0]        pitch_o
);

  localparam int DIFF_W  = mld_pkg::IN_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SHL     = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
  localparam int SHR     = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
  localparam int WIDE_W  = PROD_W + SHL;
  localparam int DELTA_W = ANGLE_FRAC_BITS + 17;
  localparam int SUM_W   = ANGLE_FRAC_BITS + 19;

  localparam logic signed [SUM_W-1:0] LIM90   = SUM_W'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] NLIM270 = SUM_W'(-270 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] LIM89   = SUM_W'(89 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] NLIM89  = SUM_W'(-89 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [YAW_W-1:0] YAW_RST = YAW_W'(-90 * (2 ** ANGLE_FRAC_BITS));

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_ACC  = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic                        first_q;
  logic signed [mld_pkg::IN_W-1:0] prev_x_q, prev_y_q;
  logic signed [YAW_W-1:0]     yaw_q;
  logic signed [PITCH_W-1:0]   pitch_q;
  logic [mld_pkg::SENS_W-1:0]  sens_q;
  logic signed [DIFF_W-1:0]    dx_q, dy_q, dx_d, dy_d;
  logic signed [DELTA_W-1:0]   dyaw_q, dpitch_q, dyaw_d, dpitch_d;
  logic signed [PROD_W-1:0]    prod_x, prod_y;
  logic signed [WIDE_W-1:0]    wide_x, wide_y;
  logic signed [SUM_W-1:0]     yaw_sum, pitch_sum, yaw_wrap, pitch_clamp;
  logic                        accept;

  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);

  // Control sequence: accept, scale, accumulate and hand over
  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_MUL;
      end
      F_MUL: begin
        state_d = F_ACC;
      end
      F_ACC: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Raw deltas; y is inverted, first item after reset gives zero
  always_comb begin
    if (first_q) begin
      dx_d = '0;
      dy_d = '0;
    end else begin
      dx_d = DIFF_W'(cursor_x_i) - DIFF_W'(prev_x_q);
      dy_d = DIFF_W'(prev_y_q) - DIFF_W'(cursor_y_i);
    end
  end

  // Scale by sensitivity, bring Q.16 to the accumulator format (floor)
  always_comb begin
    prod_x   = dx_q * $signed({1'b0, sens_q});
    prod_y   = dy_q * $signed({1'b0, sens_q});
    wide_x   = (WIDE_W'(prod_x) <<< SHL) >>> SHR;
    wide_y   = (WIDE_W'(prod_y) <<< SHL) >>> SHR;
    dyaw_d   = DELTA_W'(wide_x);
    dpitch_d = DELTA_W'(wide_y);
  end

  // Accumulate, wrap yaw, clamp pitch
  always_comb begin
    yaw_sum   = SUM_W'(yaw_q) + SUM_W'(dyaw_q);
    pitch_sum = SUM_W'(pitch_q) + SUM_W'(dpitch_q);
    yaw_wrap  = yaw_sum;
    if (yaw_wrap < NLIM270) yaw_wrap = LIM90;
    if (yaw_wrap > LIM90)   yaw_wrap = NLIM270;
    pitch_clamp = pitch_sum;
    if (pitch_clamp > LIM89)  pitch_clamp = LIM89;
    if (pitch_clamp < NLIM89) pitch_clamp = NLIM89;
    yaw_o   = YAW_W'(yaw_wrap);
    pitch_o = PITCH_W'(pitch_clamp);
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      first_q  <= 1'b1;
      prev_x_q <= '0;
      prev_y_q <= '0;
      yaw_q    <= YAW_RST;
      pitch_q  <= '0;
      sens_q   <= mld_pkg::SENS_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) sens_q <= cfg_data_i;
      if (accept) begin
        first_q  <= 1'b0;
        prev_x_q <= cursor_x_i;
        prev_y_q <= cursor_y_i;
      end
      if (push_o) begin
        yaw_q   <= yaw_o;
        pitch_q <= pitch_o;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (state_q == F_MUL) begin
      dyaw_q   <= dyaw_d;
      dpitch_q <= dpitch_d;
    end
  end

endmodule

>>> rtl/core/mld_queue.sv
// mld_queue: small register FIFO carrying angle pairs from front to back.
// Depends on mld_pkg for its default depth.
module mld_queue #(
  parameter int DATA_W = 42,
  parameter int DEPTH  = mld_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> rtl/core/mld_cordic.sv
// mld_cordic: iterative rotation-mode CORDIC, one step per cycle, cos/sin in Q1.15.
// Takes an angle in degrees with ANGLE_FRAC_BITS fraction bits. Depends on mld_pkg.
module mld_cordic #(
  parameter int ANGLE_FRAC_BITS = mld_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int ANGLE_W         = ANGLE_FRAC_BITS + 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ANGLE_W-1:0]         angle_i,
  output logic                              busy_o,
  output logic signed [mld_pkg::VEC_W-1:0]  cos_o,
  output logic signed [mld_pkg::VEC_W-1:0]  sin_o
);

  localparam int CW  = mld_pkg::CORDIC_W;
  localparam int ZW  = mld_pkg::Z_W;
  localparam int NW  = mld_pkg::CORDIC_CNT_W;
  localparam int RW  = mld_pkg::RND_W;
  localparam int UPSHIFT = mld_pkg::TRIG_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(90 * (2 ** mld_pkg::TRIG_FRAC));
  localparam logic signed [ZW-1:0] HALF    = ZW'(180 * (2 ** mld_pkg::TRIG_FRAC));
  localparam logic [NW-1:0] LAST = NW'(mld_pkg::CORDIC_STEPS - 1);

  logic signed [CW-1:0] x_q, y_q, x_d, y_d, x_sh, y_sh;
  logic signed [ZW-1:0] z_q, z_d, a20, a_fold;
  logic [NW-1:0]        cnt_q;
  logic                 busy_q, neg_q, fold_neg;
  logic signed [RW-1:0] x_rnd, y_rnd;
  logic signed [mld_pkg::VEC_W-1:0] c_sat, s_sat;

  assign busy_o = busy_q;

  // Move to Q.20 and fold into [-90, 90]; folding negates cos and sin
  always_comb begin
    a20      = ZW'(angle_i) <<< UPSHIFT;
    a_fold   = a20;
    fold_neg = 1'b0;
    if (a20 > QUARTER) begin
      a_fold   = a20 - HALF;
      fold_neg = 1'b1;
    end else if (a20 < -QUARTER) begin
      a_fold   = a20 + HALF;
      fold_neg = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    x_sh = x_q >>> cnt_q;
    y_sh = y_q >>> cnt_q;
    if (!z_q[ZW-1]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - mld_pkg::atan_q20(cnt_q);
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + mld_pkg::atan_q20(cnt_q);
    end
  end

  // Round half up to Q1.15, saturate, undo the fold
  always_comb begin
    x_rnd = RW'(x_q) + 34'sd16384;
    y_rnd = RW'(y_q) + 34'sd16384;
    c_sat = mld_pkg::clamp15(x_rnd >>> 15);
    s_sat = mld_pkg::clamp15(y_rnd >>> 15);
    cos_o = neg_q ? -c_sat : c_sat;
    sin_o = neg_q ? -s_sat : s_sat;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + NW'(1);
      if (cnt_q == LAST) busy_q <= 1'b0;
    end
  end

  // Rotation datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= mld_pkg::CORDIC_X0;
      y_q   <= '0;
      z_q   <= a_fold;
      neg_q <= fold_neg;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

endmodule

>>> rtl/core/mld_back.sv
// mld_back: takes angle pairs from the queue, runs two CORDIC lanes, forms the
// front vector and holds the result until it is taken. Depends on mld_pkg, mld_cordic.
module mld_back #(
  parameter int ANGLE_FRAC_BITS = mld_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int YAW_W           = ANGLE_FRAC_BITS + 10,
  parameter int PITCH_W         = ANGLE_FRAC_BITS + 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  empty_i,
  input  logic [YAW_W+PITCH_W-1:0]              data_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mld_pkg::YAW_OUT_W-1:0]   yaw_angle_o,
  output logic signed [mld_pkg::PITCH_OUT_W-1:0] pitch_angle_o,
  output logic signed [mld_pkg::VEC_W-1:0]       front_x_o,
  output logic signed [mld_pkg::VEC_W-1:0]       front_y_o,
  output logic signed [mld_pkg::VEC_W-1:0]       front_z_o
);

  localparam int VW = mld_pkg::VEC_W;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ROT  = 4'b0010,
    B_MUL  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic signed [YAW_W-1:0]   yaw_in, yaw_q;
  logic signed [PITCH_W-1:0] pitch_in, pitch_q;
  logic                      yaw_busy, pitch_busy;
  logic signed [VW-1:0]      cy, sy, cp, sp;
  logic signed [VW-1:0]      cy_q, sy_q, cp_q, sp_q;

  assign yaw_in      = $signed(data_i[YAW_W+PITCH_W-1 -: YAW_W]);
  assign pitch_in    = $signed(data_i[PITCH_W-1:0]);
  assign out_valid_o = (state_q == B_OUT);

  mld_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .ANGLE_W        (YAW_W)
  ) u_cordic_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pop_o),
    .angle_i(yaw_in),
    .busy_o (yaw_busy),
    .cos_o  (cy),
    .sin_o  (sy)
  );

  mld_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .ANGLE_W        (PITCH_W)
  ) u_cordic_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pop_o),
    .angle_i(pitch_in),
    .busy_o (pitch_busy),
    .cos_o  (cp),
    .sin_o  (sp)
  );

  // Sequencer: fetch, rotate, multiply, present
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_ROT;
        end
      end
      B_ROT: begin
        if (!yaw_busy && !pitch_busy) state_d = B_MUL;
      end
      B_MUL: begin
        state_d = B_OUT;
      end
      B_OUT: begin
        if (!out_stall_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Angle capture, trig capture and the output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      yaw_q   <= yaw_in;
      pitch_q <= pitch_in;
    end
    if (state_q == B_ROT) begin
      cy_q <= cy;
      sy_q <= sy;
      cp_q <= cp;
      sp_q <= sp;
    end
    if (state_q == B_MUL) begin
      yaw_angle_o   <= mld_pkg::YAW_OUT_W'(yaw_q);
      pitch_angle_o <= mld_pkg::PITCH_OUT_W'(pitch_q);
      front_x_o     <= mld_pkg::mul15(cy_q, cp_q);
      front_y_o     <= sp_q;
      front_z_o     <= mld_pkg::mul15(sy_q, cp_q);
    end
  end

endmodule

>>> rtl/core/mouse_look_direction.sv
// mouse_look_direction: top level of the mouse-look camera direction block.
// Instantiates mld_front, mld_queue and mld_back; depends on mld_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per cursor event:
//   absolute cursor_x_i / cursor_y_i in pixels. Every item gives exactly one
//   result on the output channel (out_valid_o / out_stall_i): yaw and pitch in
//   degrees with ANGLE_FRAC_BITS fraction bits, and the Q1.15 front vector.
//   The first item after reset only records the cursor position.
//   cfg_valid_i / cfg_ready_o writes the Q0.16 sensitivity (deg per pixel);
//   ready is always high, write only while the block is idle.
// Flow:
//   Front steps through accept, scale and accumulate for each item. The back
//   runs two 24-step iterative CORDIC lanes side by side and fetches the next
//   pair only after its result is taken, so throughput is set by the CORDIC
//   iteration count.
// Stalls and reset:
//   A stalled result stays in the output register; the front keeps accepting
//   until the two-entry queue fills; in_stall_o is high while front is busy.
//   Reset: yaw -90 deg, pitch 0, sensitivity 3277, no items in flight.
module mouse_look_direction #(
  parameter int ANGLE_FRAC_BITS = mld_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mld_pkg::IN_W-1:0]        cursor_x_i,
  input  logic signed [mld_pkg::IN_W-1:0]        cursor_y_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mld_pkg::SENS_W-1:0]             cfg_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [mld_pkg::YAW_OUT_W-1:0]   yaw_angle_o,
  output logic signed [mld_pkg::PITCH_OUT_W-1:0] pitch_angle_o,
  output logic signed [mld_pkg::VEC_W-1:0]       front_x_o,
  output logic signed [mld_pkg::VEC_W-1:0]       front_y_o,
  output logic signed [mld_pkg::VEC_W-1:0]       front_z_o
);

  localparam int YAW_W   = ANGLE_FRAC_BITS + 10;
  localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
  localparam int Q_W     = YAW_W + PITCH_W;

  logic                      q_push, q_full, q_pop, q_empty;
  logic signed [YAW_W-1:0]   new_yaw;
  logic signed [PITCH_W-1:0] new_pitch;
  logic [Q_W-1:0]            q_rdata;

  assign cfg_ready_o = 1'b1;

  mld_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .YAW_W          (YAW_W),
    .PITCH_W        (PITCH_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cursor_x_i (cursor_x_i),
    .cursor_y_i (cursor_y_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (q_push),
    .full_i     (q_full),
    .yaw_o      (new_yaw),
    .pitch_o    (new_pitch)
  );

  mld_queue #(
    .DATA_W(Q_W),
    .DEPTH (mld_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({new_yaw, new_pitch}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  mld_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .YAW_W          (YAW_W),
    .PITCH_W        (PITCH_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .data_i       (q_rdata),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .yaw_angle_o  (yaw_angle_o),
    .pitch_angle_o(pitch_angle_o),
    .front_x_o    (front_x_o),
    .front_y_o    (front_y_o),
    .front_z_o    (front_z_o)
  );

`ifndef SYNTHESIS
  // Front never writes into a full queue
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  // Back never reads an empty queue
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A fetch starts the CORDIC, so no result can be shown in the next cycle
  a_pop_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !out_valid_o)
    else $error("result shown right after fetch");
`endif

endmodule

>>> test/tb_top.sv
// tb_top: self-checking testbench for the mouse_look_direction camera block.
// Depends on mld_pkg and mouse_look_direction; predicts yaw, pitch and front vector.
`timescale 1ns / 1ps

module tb_top;

  // Package constants used here
  localparam int IN_W         = mld_pkg::IN_W;
  localparam int SENS_W       = mld_pkg::SENS_W;
  localparam int YAW_OUT_W    = mld_pkg::YAW_OUT_W;
  localparam int PITCH_OUT_W  = mld_pkg::PITCH_OUT_W;
  localparam int VEC_W        = mld_pkg::VEC_W;
  localparam int TRIG_FRAC    = mld_pkg::TRIG_FRAC;
  localparam int CORDIC_STEPS = mld_pkg::CORDIC_STEPS;
  localparam logic [SENS_W-1:0] SENS_RESET = mld_pkg::SENS_RESET;

  localparam int FRAC = mld_pkg::ANGLE_FRAC_BITS_DEF;

  // Angle limits in accumulator format, trig folding limits in Q.20 degrees
  localparam longint DEG90      = longint'(90) <<< FRAC;
  localparam longint DEG89      = longint'(89) <<< FRAC;
  localparam longint DEG270     = longint'(270) <<< FRAC;
  localparam longint TRIG_SCALE = longint'(1) <<< (TRIG_FRAC - FRAC);
  localparam longint QUARTER    = longint'(90) <<< TRIG_FRAC;
  localparam longint HALF       = longint'(180) <<< TRIG_FRAC;
  localparam longint GAIN_X0    = 64'sd652032874;
  localparam longint ATAN_Q20 [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [YAW_OUT_W-1:0]   yaw;
    logic signed [PITCH_OUT_W-1:0] pitch;
    logic signed [VEC_W-1:0]       fx;
    logic signed [VEC_W-1:0]       fy;
    logic signed [VEC_W-1:0]       fz;
  } look_result_t;

  logic                          clk;
  logic                          rst_ni     = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic signed [IN_W-1:0]        cursor_x   = '0;
  logic signed [IN_W-1:0]        cursor_y   = '0;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [SENS_W-1:0]             cfg_data   = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic signed [YAW_OUT_W-1:0]   yaw_angle;
  logic signed [PITCH_OUT_W-1:0] pitch_angle;
  logic signed [VEC_W-1:0]       front_x;
  logic signed [VEC_W-1:0]       front_y;
  logic signed [VEC_W-1:0]       front_z;

  // Predicted camera state
  bit                cam_first;
  longint            cam_prev_x;
  longint            cam_prev_y;
  longint            cam_yaw;
  longint            cam_pitch;
  logic [SENS_W-1:0] cam_sens;

  look_result_t pending_looks[$];
  int unsigned  mismatches     = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  logic signed [IN_W-1:0] last_x = '0;
  logic signed [IN_W-1:0] last_y = '0;

  mouse_look_direction u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cursor_x_i    (cursor_x),
    .cursor_y_i    (cursor_y),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .yaw_angle_o   (yaw_angle),
    .pitch_angle_o (pitch_angle),
    .front_x_o     (front_x),
    .front_y_o     (front_y),
    .front_z_o     (front_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  function automatic longint q15_product(input longint a, input longint b);
    return sat15((a * b + 16384) >>> 15);
  endfunction

  // pixels times Q0.16 sensitivity, taken to FRAC fraction bits, floor rounding
  function automatic longint scaled_degrees(input longint d);
    longint p;
    p = d * longint'(cam_sens);
    return (p <<< FRAC) >>> 16;
  endfunction

  // cos/sin of a Q.20 degree angle in [-270, 270], Q1.15 results
  function automatic void trig_q15(input longint angle, output longint c, output longint s);
    longint x, y, z, t;
    bit     flip;
    x    = GAIN_X0;
    y    = 0;
    flip = 1'b0;
    // fold into [-90, 90]; the half turn negates both outputs
    if (angle > QUARTER) begin
      angle -= HALF;
      flip = 1'b1;
    end else if (angle < -QUARTER) begin
      angle += HALF;
      flip = 1'b1;
    end
    z = angle;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z -= ATAN_Q20[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z += ATAN_Q20[i];
      end
    end
    x = sat15((x + 16384) >>> 15);
    y = sat15((y + 16384) >>> 15);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic look_result_t predict_look(input logic signed [IN_W-1:0] x,
                                                input logic signed [IN_W-1:0] y);
    longint       cy, sy, cp, sp;
    look_result_t r;
    // first event after reset only records the position
    if (cam_first) begin
      cam_prev_x = x;
      cam_prev_y = y;
      cam_first  = 1'b0;
    end
    cam_yaw   += scaled_degrees(longint'(x) - cam_prev_x);
    cam_pitch += scaled_degrees(cam_prev_y - longint'(y));
    cam_prev_x = x;
    cam_prev_y = y;
    // yaw wraps (low test first), pitch clamps
    if (cam_yaw < -DEG270) cam_yaw = DEG90;
    if (cam_yaw > DEG90) cam_yaw = -DEG270;
    if (cam_pitch > DEG89) cam_pitch = DEG89;
    if (cam_pitch < -DEG89) cam_pitch = -DEG89;
    trig_q15(cam_yaw * TRIG_SCALE, cy, sy);
    trig_q15(cam_pitch * TRIG_SCALE, cp, sp);
    r.yaw   = YAW_OUT_W'(cam_yaw);
    r.pitch = PITCH_OUT_W'(cam_pitch);
    r.fx    = VEC_W'(q15_product(cy, cp));
    r.fy    = VEC_W'(sp);
    r.fz    = VEC_W'(q15_product(sy, cp));
    return r;
  endfunction

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin : result_check
    look_result_t want;
    look_result_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{yaw_angle, pitch_angle, front_x, front_y, front_z};
      if (pending_looks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result yaw=%0d pitch=%0d front=(%0d,%0d,%0d)",
                   $realtime, got.yaw, got.pitch, got.fx, got.fy, got.fz);
      end else begin
        want = pending_looks.pop_front();
        if (got.yaw !== want.yaw || got.pitch !== want.pitch || got.fx !== want.fx ||
            got.fy !== want.fy || got.fz !== want.fz) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp yaw=%0d pitch=%0d front=(%0d,%0d,%0d)",
                     $realtime, want.yaw, want.pitch, want.fx, want.fy, want.fz);
            $display("%0t:          got yaw=%0d pitch=%0d front=(%0d,%0d,%0d)",
                     $realtime, got.yaw, got.pitch, got.fx, got.fy, got.fz);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- drivers

  // one cursor item; valid stays high afterwards until the next call or a drain
  task automatic send_cursor(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cursor_x <= x;
    cursor_y <= y;
    do @(posedge clk); while (in_stall);
    pending_looks.push_back(predict_look(x, y));
    last_x = x;
    last_y = y;
  endtask

  // stop sending and wait until every predicted result has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_looks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sensitivity write, only with the block idle
  task automatic write_sensitivity(input logic [SENS_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cam_sens = value;
  endtask

  // ---------------------------------------------------------------- tests

  // first item after reset only latches the position: yaw -90, pitch 0
  task automatic test_first_item();
    send_cursor(16'sh7FFF, -16'sh8000);
  endtask

  // full-scale jumps at the reset sensitivity: wrap both ways, clamp both ways
  task automatic test_wrap_and_clamp();
    send_cursor(-16'sh8000, 16'sh7FFF);
    send_cursor(16'sh7FFF, -16'sh8000);
    send_cursor(16'sh0000, 16'sh0000);
    send_cursor(16'sh0000, 16'sh0000);
    send_cursor(16'sh5555, -16'sh5556);
    send_cursor(-16'sh2AAB, 16'sh2AAA);
  endtask

  // zero, full and smallest sensitivity
  task automatic test_sensitivity_extremes();
    write_sensitivity(16'h0000);
    send_cursor(-16'sh8000, 16'sh7FFF);
    send_cursor(16'sh7FFF, -16'sh8000);
    write_sensitivity(16'hFFFF);
    send_cursor(16'sh7FFE, -16'sh7FFF);
    send_cursor(16'sh7F00, -16'sh7F80);
    send_cursor(16'sh7FFF, -16'sh8000);
    send_cursor(-16'sh8000, 16'sh7FFF);
    write_sensitivity(16'h0001);
    send_cursor(-16'sh7FFF, 16'sh7FFE);
    send_cursor(16'sh7FFF, -16'sh8000);
  endtask

  // random cursor motion: mostly small moves so the angles sweep smoothly,
  // some medium moves, some fully random positions
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned stall_pct,
                                   input logic [SENS_W-1:0] sens, input int n_items,
                                   input bit pause_midway);
    int                     kind;
    logic signed [IN_W-1:0] nx, ny;
    write_sensitivity(sens);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        nx = last_x + IN_W'(int'($urandom_range(128)) - 64);
        ny = last_y + IN_W'(int'($urandom_range(128)) - 64);
      end else if (kind < 90) begin
        nx = last_x + IN_W'(int'($urandom_range(4000)) - 2000);
        ny = last_y + IN_W'(int'($urandom_range(4000)) - 2000);
      end else begin
        nx = IN_W'($urandom);
        ny = IN_W'($urandom);
      end
      send_cursor(nx, ny);
      if (pause_midway && i == n_items / 2) drain_results();
    end
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    cam_first  = 1'b1;
    cam_prev_x = 0;
    cam_prev_y = 0;
    cam_yaw    = -DEG90;
    cam_pitch  = 0;
    cam_sens   = SENS_RESET;

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_first_item();
    test_wrap_and_clamp();
    test_sensitivity_extremes();
    test_random_phase(0, 0, SENS_RESET, 420, 1'b0);
    test_random_phase(53, 0, SENS_W'($urandom_range(65535)), 420, 1'b1);
    test_random_phase(0, 53, 16'hFFFF, 420, 1'b0);
    test_random_phase(7, 7, SENS_W'($urandom_range(1, 8000)), 420, 1'b0);

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_looks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mld_pkg.sv
rtl/core/mld_front.sv
rtl/core/mld_queue.sv
rtl/core/mld_cordic.sv
rtl/core/mld_back.sv
rtl/core/mouse_look_direction.sv
test/tb_top.sv
